@@ rtl/collision_pair_filter_table_macros.svh @@
// Assertion macros for the collision pair filter table checker.
// No dependencies.
`ifndef COLLISION_PAIR_FILTER_TABLE_MACROS_SVH
`define COLLISION_PAIR_FILTER_TABLE_MACROS_SVH
// Assert an implication with a message.
`define CPFT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`endif

@@ rtl/cpft_pkg.sv @@
// Package for the collision pair filter table: sizes, request codes, types.
// No dependencies.
`timescale 1ns / 1ps
package cpft_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = 7;
  localparam int KeyW = 64;

  // Fallback mode register codes
  localparam logic [1:0] MODE_AND       = 2'd0;
  localparam logic [1:0] MODE_OR        = 2'd1;
  localparam logic [1:0] MODE_NONE      = 2'd2;
  localparam logic [1:0] MODE_ALSO_NONE = 2'd3;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // datapath -> controller (unused fields kept minimal)
  typedef struct packed {
    logic busy;
  } sts_t;
endpackage

@@ rtl/cpft_ctrl.sv @@
// Controller state machine for the collision pair filter table.
// Depends on cpft_pkg.
`timescale 1ns / 1ps
module cpft_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cpft_pkg::cmd_t cmd_o
);
  import cpft_pkg::*;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = in_valid_i ? ST_LOOK : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOK: cmd_o.exec = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        cmd_o.load  = out_ready_i & in_valid_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule

@@ rtl/cpft_datapath.sv @@
// Datapath: request register, rule table, parallel compare, result register.
// Depends on cpft_pkg.
`timescale 1ns / 1ps
module cpft_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpft_pkg::cmd_t cmd_i,
  input  logic [1:0]     mode_i,
  input  logic [199:0]   req_i,
  output logic [15:0]    res_o
);
  import cpft_pkg::*;
  logic [199:0] req_q;
  logic [TableDepth-1:0] valid_q;
  logic [KeyW-1:0] key_q [TableDepth];
  logic [TableDepth-1:0] en_q;
  logic [CntW-1:0] total_q;
  logic [15:0] res_q, res_d;

  logic [1:0] rt;
  logic [15:0] oa, ob, la, lb;
  logic [31:0] ga, ma, gb, mb;
  logic swap;
  logic [KeyW-1:0] key;
  logic [TableDepth-1:0] match, freev;
  logic hit, has_free, en_hit, ab, ba, coll;
  logic [IdxW-1:0] hidx, fidx;

  assign rt = req_q[1:0];
  assign oa = req_q[17:2];
  assign la = req_q[33:18];
  assign ob = req_q[49:34];
  assign lb = req_q[65:50];
  assign ga = req_q[98:67];
  assign ma = req_q[130:99];
  assign gb = req_q[162:131];
  assign mb = req_q[194:163];
  assign swap = (oa > ob) || ((oa == ob) && ($signed(la) > $signed(lb)));
  assign key = swap ? {ob, lb, oa, la} : {oa, la, ob, lb};

  always_comb begin
    hidx = '0;
    fidx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (key_q[i] == key);
      freev[i] = !valid_q[i];
      if (match[i]) hidx = IdxW'(i);
      if (freev[i]) fidx = IdxW'(i);
    end
  end
  assign hit = |match;
  assign has_free = |freev;
  assign en_hit = en_q[hidx];
  assign ab = |(ga & mb);
  assign ba = |(gb & ma);

  always_comb begin
    case (mode_i)
      MODE_AND: coll = ab & ba;
      MODE_OR:  coll = ab | ba;
      default:  coll = 1'b0;
    endcase
  end

  // result fields: collide, rule_hit, rule_count, table_full
  always_comb begin
    res_d = res_q;
    if (cmd_i.exec) begin
      res_d = '0;
      unique case (rt)
        REQ_SET: begin
          res_d[1]   = hit;
          res_d[9]   = !hit && !has_free;
          res_d[8:2] = (!hit && has_free) ? total_q + CntW'(1) : total_q;
        end
        REQ_REMOVE: begin
          res_d[1]   = hit;
          res_d[8:2] = hit ? total_q - CntW'(1) : total_q;
        end
        REQ_QUERY: begin
          res_d[1]   = hit;
          res_d[0]   = hit ? en_hit : coll;
          res_d[8:2] = total_q;
        end
        REQ_CLEAR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.exec) begin
      if (rt == REQ_SET) begin
        if (hit) en_q[hidx] <= req_q[66];
        else if (has_free) begin
          key_q[fidx] <= key;
          en_q[fidx]  <= req_q[66];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      total_q <= '0;
      res_q   <= '0;
    end else begin
      res_q <= res_d;
      if (cmd_i.exec) begin
        unique case (rt)
          REQ_SET: begin
            if (!hit && has_free) begin
              valid_q[fidx] <= 1'b1;
              total_q <= total_q + CntW'(1);
            end
          end
          REQ_REMOVE: begin
            if (hit) begin
              valid_q[hidx] <= 1'b0;
              total_q <= total_q - CntW'(1);
            end
          end
          REQ_QUERY: ;
          REQ_CLEAR: begin
            valid_q <= '0;
            total_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end
  assign res_o = res_q;
endmodule

@@ rtl/collision_pair_filter_table.sv @@
// Collision pair filter table: 64-entry per-pair rule table, parallel compare.
// An input transfer loads the request register; the single lookup/update step then
// fills the result register; a new request enters when idle or as a result leaves.
// Reset: rst_ni asynchronous low clears all valid bits, rule count, fallback mode.
// Depends on cpft_pkg, cpft_ctrl, cpft_datapath.
`timescale 1ns / 1ps
module collision_pair_filter_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: req_type, object_a, link_a, object_b, link_b, enable_flag,
  //        group_a, mask_a, group_b, mask_b (low to high)
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: collide, rule_hit, rule_count[6:0], table_full (low to high)
  output logic [15:0]  m_axis_tdata
);
  import cpft_pkg::*;
  cmd_t cmd;
  logic [1:0] mode_q;

  // hold fallback mode; the user must write it only while idle, since no logic here checks that
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= MODE_AND;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  cpft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd)
  );

  cpft_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .mode_i(mode_q),
    .req_i(s_axis_tdata), .res_o(m_axis_tdata)
  );
endmodule

@@ rtl/cpft_checker.sv @@
// Port-level checker for the collision pair filter table, bound to the top.
// Depends on collision_pair_filter_table_macros.svh.
`timescale 1ns / 1ps
`include "collision_pair_filter_table_macros.svh"
module cpft_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  `CPFT_ASSERT(a_cnt_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[8:2] <= 7'd64, "count")
  `CPFT_ASSERT(a_full_nohit, clk_i, rst_ni, m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[1]), "full")
  `CPFT_ASSERT(a_in_out, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid, "lat")
  `CPFT_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "hold")
endmodule

bind collision_pair_filter_table cpft_checker u_chk (.*);

@@ tb/collision_pair_filter_table_tb.sv @@
// Self-checking testbench for collision_pair_filter_table: directed table plus random traffic.
// Each accepted request is checked against a local rule-table predictor.
// Depends on cpft_pkg and the collision_pair_filter_table RTL.
`timescale 1ns / 1ps
module collision_pair_filter_table_tb;
  import cpft_pkg::*;

  localparam int Depth = 64;
  localparam int CycleLimit = 400000;

  typedef struct {
    req_e               req;
    logic [15:0]        obj_a;
    logic signed [15:0] link_a;
    logic [15:0]        obj_b;
    logic signed [15:0] link_b;
    logic               en;
    logic [31:0]        ga, ma, gb, mb;
  } pair_req_t;

  typedef struct packed {
    logic       collide;
    logic       hit;
    logic [6:0] count;
    logic       full;
  } verdict_t;

  typedef struct {
    verdict_t pred;
    bit       has_fixed;
    verdict_t fixed;
  } pending_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_wdata_i = 2'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  collision_pair_filter_table dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a private copy of the rule table and the fallback mode.
  logic        rule_on [Depth];
  logic [63:0] rule_key [Depth];
  logic        rule_en [Depth];
  int          rule_cnt;
  logic [1:0]  fb_mode;

  pending_t    verdict_q[$];
  int          err_cnt;
  int          cycles;
  bit          no_stall;
  // Typed expectation riding with the request being offered
  bit          cur_has_fixed;
  verdict_t    cur_fixed;
  pair_req_t   cur_req;

  function automatic logic [199:0] pack_req(pair_req_t r);
    return {5'b0, r.mb, r.gb, r.ma, r.ga, r.en, r.link_b, r.obj_b, r.link_a, r.obj_a, r.req};
  endfunction

  function automatic pair_req_t mk(req_e r, int oa, int la, int ob, int lb, bit en,
                                   logic [31:0] ga, logic [31:0] ma,
                                   logic [31:0] gb, logic [31:0] mb);
    pair_req_t p;
    p.req = r; p.obj_a = 16'(oa); p.link_a = 16'(la); p.obj_b = 16'(ob); p.link_b = 16'(lb);
    p.en = en; p.ga = ga; p.ma = ma; p.gb = gb; p.mb = mb;
    return p;
  endfunction

  function automatic verdict_t vd(bit c, bit h, int n, bit f);
    verdict_t v;
    v.collide = c; v.hit = h; v.count = 7'(n); v.full = f;
    return v;
  endfunction

  // Apply one request to the rule table and return what the block must answer.
  function automatic verdict_t apply_pair_req(pair_req_t r);
    verdict_t    v;
    logic [63:0] key;
    int          hit_at, free_at;
    bit          ab, ba;
    v = vd(0, 0, 0, 0);
    // Canonical order: lower object first, then lower link (signed) for the same object
    if (r.obj_a > r.obj_b || (r.obj_a == r.obj_b && r.link_a > r.link_b))
      key = {r.obj_b, r.link_b, r.obj_a, r.link_a};
    else
      key = {r.obj_a, r.link_a, r.obj_b, r.link_b};
    hit_at = -1;
    free_at = -1;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (rule_on[i] && rule_key[i] == key) hit_at = i;
      if (!rule_on[i]) free_at = i;
    end
    case (r.req)
      REQ_SET: begin
        if (hit_at >= 0) begin
          rule_en[hit_at] = r.en;
          v.hit = 1;
        end else if (free_at < 0) begin
          v.full = 1;
        end else begin
          rule_on[free_at] = 1;
          rule_key[free_at] = key;
          rule_en[free_at] = r.en;
          rule_cnt++;
        end
      end
      REQ_REMOVE: begin
        if (hit_at >= 0) begin
          rule_on[hit_at] = 0;
          rule_cnt--;
          v.hit = 1;
        end
      end
      REQ_QUERY: begin
        if (hit_at >= 0) begin
          v.hit = 1;
          v.collide = rule_en[hit_at];
        end else begin
          ab = (r.ga & r.mb) != 0;
          ba = (r.gb & r.ma) != 0;
          case (fb_mode)
            MODE_AND: v.collide = ab && ba;
            MODE_OR:  v.collide = ab || ba;
            default:  v.collide = 0;
          endcase
        end
      end
      default: begin
        for (int i = 0; i < Depth; i++) rule_on[i] = 0;
        rule_cnt = 0;
      end
    endcase
    v.count = rule_cnt[6:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Predict at every input transfer.
  always @(posedge clk_i) begin
    pending_t p;
    if (s_axis_tvalid && s_axis_tready) begin
      p.pred = apply_pair_req(cur_req);
      p.has_fixed = cur_has_fixed;
      p.fixed = cur_fixed;
      verdict_q.push_back(p);
    end
  end

  // Check every output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    pending_t p;
    verdict_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = vd(m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[8:2], m_axis_tdata[9]);
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        p = verdict_q.pop_front();
        if (got.collide != p.pred.collide) report_mismatch("collide", got.collide, p.pred.collide);
        if (got.hit != p.pred.hit) report_mismatch("rule_hit", got.hit, p.pred.hit);
        if (got.count != p.pred.count) report_mismatch("rule_count", got.count, p.pred.count);
        if (got.full != p.pred.full) report_mismatch("table_full", got.full, p.pred.full);
        if (p.has_fixed && got != p.fixed)
          report_mismatch("typed expectation", {got.collide, got.hit, got.count, got.full},
                          {p.fixed.collide, p.fixed.hit, p.fixed.count, p.fixed.full});
      end
    end
  end

  // Receiver: drop ready for a random gap before each result unless no_stall is set, hold ready until transfer.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("collision_pair_filter_table_tb: FAIL");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until the transfer.
  task automatic send_pair_req(pair_req_t r, bit has_fixed, verdict_t fixed);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_req(r);
    cur_req <= r;
    cur_has_fixed <= has_fixed;
    cur_fixed <= fixed;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Drain all results, let the pipeline settle, then write the fallback mode.
  task automatic write_mode(logic [1:0] m);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fb_mode = m;
  endtask

  function automatic logic [15:0] pick_obj();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 16'($urandom_range(0, 5));
    if (r == 8) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [15:0] pick_link();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($signed($urandom_range(0, 2)) - 1);
    if (r == 7) return 16'sd32767;
    return 16'($urandom_range(0, 32767));
  endfunction

  function automatic logic [31:0] pick_bits();
    return $urandom_range(0, 1) ? $urandom() : (32'd1 << $urandom_range(0, 31));
  endfunction

  function automatic pair_req_t rand_pair_req();
    pair_req_t r;
    int w;
    w = $urandom_range(0, 99);
    r = mk(w < 35 ? REQ_SET : w < 50 ? REQ_REMOVE : w < 98 ? REQ_QUERY : REQ_CLEAR,
           pick_obj(), pick_link(), pick_obj(), pick_link(), 1'($urandom_range(0, 1)),
           pick_bits(), pick_bits(), pick_bits(), pick_bits());
    return r;
  endfunction

  pair_req_t dir_req [16];
  verdict_t  dir_want [16];
  bit        dir_typed [16];
  logic [1:0] phase_mode [6] = '{MODE_OR, MODE_NONE, MODE_ALSO_NONE, MODE_AND, MODE_OR, MODE_AND};

  initial begin
    pair_req_t r;
    err_cnt = 0;
    cycles = 0;
    no_stall = 0;
    fb_mode = MODE_AND;
    rule_cnt = 0;
    for (int i = 0; i < Depth; i++) rule_on[i] = 0;
    cur_has_fixed = 0;
    cur_fixed = vd(0, 0, 0, 0);
    cur_req = mk(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // Directed rows; typed expectations only where obvious, others predictor-only.
    dir_req[0]  = mk(REQ_QUERY, 0, -1, 0, -1, 0, 0, 0, 0, 0);
    dir_want[0] = vd(0, 0, 0, 0);  dir_typed[0] = 1;
    dir_req[1]  = mk(REQ_SET, 5, 3, 2, -1, 1, 0, 0, 0, 0);
    dir_want[1] = vd(0, 0, 1, 0);  dir_typed[1] = 1;
    // Reversed order must hit the same rule
    dir_req[2]  = mk(REQ_QUERY, 2, -1, 5, 3, 0, 0, 0, 0, 0);
    dir_want[2] = vd(1, 1, 1, 0);  dir_typed[2] = 1;
    dir_req[3]  = mk(REQ_SET, 2, -1, 5, 3, 0, 0, 0, 0, 0);
    dir_want[3] = vd(0, 1, 1, 0);  dir_typed[3] = 1;
    dir_req[4]  = mk(REQ_QUERY, 5, 3, 2, -1, 0, '1, '1, '1, '1);
    dir_want[4] = vd(0, 1, 1, 0);  dir_typed[4] = 1;
    // Same object: lower signed link first
    dir_req[5]  = mk(REQ_SET, 7, 32767, 7, -1, 1, 0, 0, 0, 0);
    dir_want[5] = vd(0, 0, 2, 0);  dir_typed[5] = 1;
    dir_req[6]  = mk(REQ_QUERY, 7, -1, 7, 32767, 0, 0, 0, 0, 0);
    dir_want[6] = vd(1, 1, 2, 0);  dir_typed[6] = 1;
    dir_req[7]  = mk(REQ_SET, 65535, 32767, 0, -1, 1, 0, 0, 0, 0);
    dir_want[7] = vd(0, 0, 3, 0);  dir_typed[7] = 1;
    dir_req[8]  = mk(REQ_QUERY, 0, -1, 65535, 32767, 0, 0, 0, 0, 0);
    dir_want[8] = vd(1, 1, 3, 0);  dir_typed[8] = 1;
    // Remove of a missing rule changes nothing
    dir_req[9]  = mk(REQ_REMOVE, 1, 1, 1, 1, 0, 0, 0, 0, 0);
    dir_want[9] = vd(0, 0, 3, 0);  dir_typed[9] = 1;
    dir_req[10] = mk(REQ_REMOVE, 2, -1, 5, 3, 0, 0, 0, 0, 0);
    dir_want[10] = vd(0, 1, 2, 0); dir_typed[10] = 1;
    dir_req[11] = mk(REQ_QUERY, 5, 3, 2, -1, 0, '1, '1, '1, '1);
    dir_want[11] = vd(1, 0, 2, 0); dir_typed[11] = 1;
    // One direction only: AND mode says no
    dir_req[12] = mk(REQ_QUERY, 9, 0, 4, 0, 0, 32'h8000_0001, 0, 0, 32'h0000_0001);
    dir_want[12] = vd(0, 0, 2, 0); dir_typed[12] = 1;
    dir_req[13] = mk(REQ_QUERY, 9, 0, 4, 0, 0, 32'h00F0_0000, 32'h0000_0100,
                     32'h0000_0300, 32'h0030_0000);
    dir_typed[13] = 0;
    dir_req[14] = mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_want[14] = vd(0, 0, 0, 0); dir_typed[14] = 1;
    dir_req[15] = mk(REQ_QUERY, 7, -1, 7, 32767, 0, '1, '1, '1, '1);
    dir_want[15] = vd(1, 0, 0, 0); dir_typed[15] = 1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(MODE_AND);

    foreach (dir_req[i]) send_pair_req(dir_req[i], dir_typed[i], dir_want[i]);

    // Random phases, each under its own fallback mode; one runs without gaps,
    // one fills the table past its depth to reach the full-table drop.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(phase_mode[ph]);
      no_stall = (ph == 2);
      for (int n = 0; n < 65; n++) begin
        if (ph == 3 && n < 70 - 5) begin
          r = rand_pair_req();
          r.req = REQ_SET;
          r.obj_a = 16'd1000 + 16'(n);
          r.obj_b = 16'd2000;
        end else begin
          r = rand_pair_req();
        end
        send_pair_req(r, 0, vd(0, 0, 0, 0));
      end
      if (ph == 3)
        for (int n = 0; n < 8; n++) begin
          r = rand_pair_req();
          r.req = REQ_SET;
          r.obj_a = 16'd3000 + 16'(n);
          send_pair_req(r, 0, vd(0, 0, 0, 0));
        end
    end
    no_stall = 0;

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("collision_pair_filter_table_tb: PASS");
    else
      $display("collision_pair_filter_table_tb: FAIL");
    $finish;
  end
endmodule
